### sv/txp_pkg.sv
// txp_pkg: widths, latencies, register codes and the arctangent table
// shared by the tunnel pixel pipeline. No dependencies.
package txp_pkg;

   localparam int CSR_DATA_W  = 16;
   localparam int CSR_INDEX_W = 3;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CENTER_X    = 3'd0,
      CSR_CENTER_Y    = 3'd1,
      CSR_DEPTH_SCALE = 3'd2,
      CSR_ROT_SPEED   = 3'd3,
      CSR_FLY_SPEED   = 3'd4
   } csr_index_type;

   localparam logic [8:0]  CENTER_X_RST    = 9'd160;
   localparam logic [7:0]  CENTER_Y_RST    = 8'd120;
   localparam logic [15:0] DEPTH_SCALE_RST = 16'd8192;
   localparam logic [7:0]  ROT_SPEED_RST   = 8'd2;
   localparam logic [7:0]  FLY_SPEED_RST   = 8'd4;

   localparam int DX_W = 10;   // signed column offset
   localparam int DY_W = 9;    // signed row offset
   localparam int R2_W = 19;   // dx*dx + dy*dy
   localparam int D2_W = 32;   // depth_scale squared

   localparam int DIV_STAGES     = D2_W;
   localparam int SQRT_STAGES    = D2_W / 2;
   localparam int CORDIC_STEPS   = 30;
   localparam int CORDIC_LATENCY = CORDIC_STEPS + 2;
   // from the first register stage to the last depth stage
   localparam int SIDE_DELAY  = 1 + DIV_STAGES + SQRT_STAGES;
   localparam int ANGLE_DELAY = SIDE_DELAY - CORDIC_LATENCY;

   // arctan(2^-i) in units of 2^-32 turn, truncated
   localparam logic [31:0] ATAN_TAB [CORDIC_STEPS] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
      32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
      32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
      32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001
   };

   // per-pixel data that rides alongside the depth pipeline
   typedef struct packed {
      logic       zero;   // pixel sits on the centre
      logic [7:0] frame;
      logic [7:0] rot_ofs;
      logic [7:0] fly_ofs;
   } side_type;

endpackage

### sv/txp_div.sv
// txp_div: pipelined restoring divider, one quotient bit per stage.
// Depends on txp_pkg for widths.
module txp_div (
   input  logic                        clock,
   input  logic [txp_pkg::D2_W-1:0]    num,
   input  logic [txp_pkg::R2_W-1:0]    den,
   output logic [txp_pkg::D2_W-1:0]    quo
);

   logic [txp_pkg::D2_W-1:0] num_ff [txp_pkg::DIV_STAGES+1];
   logic [txp_pkg::D2_W-1:0] quo_ff [txp_pkg::DIV_STAGES+1];
   logic [txp_pkg::R2_W-1:0] rem_ff [txp_pkg::DIV_STAGES+1];
   logic [txp_pkg::R2_W-1:0] den_ff [txp_pkg::DIV_STAGES+1];

   always_comb begin
      num_ff[0] = num;
      quo_ff[0] = '0;
      rem_ff[0] = '0;
      den_ff[0] = den;
   end

   for (genvar k = 0; k < txp_pkg::DIV_STAGES; k++) begin : g_stage
      logic [txp_pkg::R2_W:0]   trial;
      logic                     ge;
      logic [txp_pkg::R2_W:0]   diff;
      logic [txp_pkg::R2_W-1:0] rem_in;
      always_comb begin
         trial  = {rem_ff[k], num_ff[k][txp_pkg::D2_W-1]};
         ge     = trial >= {1'b0, den_ff[k]};
         diff   = trial - {1'b0, den_ff[k]};
         rem_in = ge ? diff[txp_pkg::R2_W-1:0] : trial[txp_pkg::R2_W-1:0];
      end
      always_ff @(posedge clock) begin
         num_ff[k+1] <= {num_ff[k][txp_pkg::D2_W-2:0], 1'b0};
         quo_ff[k+1] <= {quo_ff[k][txp_pkg::D2_W-2:0], ge};
         rem_ff[k+1] <= rem_in;
         den_ff[k+1] <= den_ff[k];
      end
   end

   assign quo = quo_ff[txp_pkg::DIV_STAGES];

endmodule

### sv/txp_sqrt.sv
// txp_sqrt: pipelined integer square root, one root bit per stage.
// Depends on txp_pkg for widths.
module txp_sqrt (
   input  logic                           clock,
   input  logic [txp_pkg::D2_W-1:0]       rad,
   output logic [txp_pkg::SQRT_STAGES-1:0] root
);

   localparam int RW = txp_pkg::SQRT_STAGES;   // root width
   localparam int MW = RW + 2;                  // remainder width

   logic [txp_pkg::D2_W-1:0] rad_ff  [RW+1];
   logic [RW-1:0]            root_ff [RW+1];
   logic [MW-1:0]            rem_ff  [RW+1];

   always_comb begin
      rad_ff[0]  = rad;
      root_ff[0] = '0;
      rem_ff[0]  = '0;
   end

   for (genvar k = 0; k < RW; k++) begin : g_stage
      logic [MW+1:0] sh;
      logic [MW+1:0] trial;
      logic [MW+1:0] diff;
      logic          ge;
      always_comb begin
         sh    = {rem_ff[k], rad_ff[k][txp_pkg::D2_W-1 -: 2]};
         trial = {2'b00, root_ff[k], 2'b01};
         ge    = sh >= trial;
         diff  = sh - trial;
      end
      always_ff @(posedge clock) begin
         rad_ff[k+1]  <= {rad_ff[k][txp_pkg::D2_W-3:0], 2'b00};
         root_ff[k+1] <= {root_ff[k][RW-2:0], ge};
         rem_ff[k+1]  <= ge ? diff[MW-1:0] : sh[MW-1:0];
      end
   end

   assign root = root_ff[RW];

endmodule

### sv/txp_cordic.sv
// txp_cordic: octant fold, vectoring CORDIC and quadrant unfold giving an
// 8-bit angle index. Depends on txp_pkg for the arctangent table.
module txp_cordic (
   input  logic                           clock,
   input  logic signed [txp_pkg::DX_W-1:0] dx,
   input  logic signed [txp_pkg::DY_W-1:0] dy,
   output logic [7:0]                      angle
);

   localparam int N  = txp_pkg::CORDIC_STEPS;
   localparam int XW = 44;
   localparam int DX_W_M1 = txp_pkg::DX_W - 1;

   typedef struct packed {
      logic zero;
      logic edge0;
      logic edge45;
      logic swap;
      logic neg_x;
      logic neg_y;
   } oct_type;

   logic signed [XW-1:0] x_ff [N+1];
   logic signed [XW-1:0] y_ff [N+1];
   logic [31:0]          z_ff [N+1];
   oct_type              oct_ff [N+1];
   logic [7:0]           angle_ff;

   // fold into first octant
   logic [DX_W_M1:0] ax;
   logic [DX_W_M1:0] ay;
   logic [DX_W_M1:0] big;
   logic [DX_W_M1:0] lit;
   oct_type          oct_in;

   always_comb begin
      ax  = dx[DX_W_M1] ? -dx : dx;
      ay  = dy[txp_pkg::DY_W-1] ? -{{1{dy[txp_pkg::DY_W-1]}}, dy} : {1'b0, dy};
      oct_in.swap   = ay > ax;
      big           = oct_in.swap ? ay : ax;
      lit           = oct_in.swap ? ax : ay;
      oct_in.zero   = (ax == '0) && (ay == '0);
      oct_in.edge0  = lit == '0;
      oct_in.edge45 = lit == big;
      oct_in.neg_x  = dx[DX_W_M1];
      oct_in.neg_y  = dy[txp_pkg::DY_W-1];
   end

   always_ff @(posedge clock) begin
      x_ff[0]   <= $signed({2'b00, big, 32'd0});
      y_ff[0]   <= $signed({2'b00, lit, 32'd0});
      z_ff[0]   <= '0;
      oct_ff[0] <= oct_in;
   end

   for (genvar i = 0; i < N; i++) begin : g_step
      logic signed [XW-1:0] xs;
      logic signed [XW-1:0] ys;
      always_comb begin
         xs = x_ff[i] >>> i;
         ys = y_ff[i] >>> i;
      end
      always_ff @(posedge clock) begin
         if (!y_ff[i][XW-1]) begin
            x_ff[i+1] <= x_ff[i] + ys;
            y_ff[i+1] <= y_ff[i] - xs;
            z_ff[i+1] <= z_ff[i] + txp_pkg::ATAN_TAB[i];
         end else begin
            x_ff[i+1] <= x_ff[i] - ys;
            y_ff[i+1] <= y_ff[i] + xs;
            z_ff[i+1] <= z_ff[i] - txp_pkg::ATAN_TAB[i];
         end
         oct_ff[i+1] <= oct_ff[i];
      end
   end

   // unfold to a full turn, then rotate by half a turn
   logic [31:0] oa;
   logic [31:0] t;
   logic [31:0] b;
   logic [31:0] idx;

   always_comb begin
      priority if (oct_ff[N].edge0) begin
         oa = '0;
      end else if (oct_ff[N].edge45) begin
         oa = 32'h20000000;
      end else begin
         oa = z_ff[N];
      end
      t = oct_ff[N].swap ? 32'h40000000 - oa : oa;
      unique case ({oct_ff[N].neg_x, oct_ff[N].neg_y})
         2'b00:   b = t;
         2'b10:   b = 32'h80000000 - t;
         2'b11:   b = 32'h80000000 + t;
         default: b = 32'd0 - t;
      endcase
      idx = b + 32'h80000000;
   end

   always_ff @(posedge clock) begin
      angle_ff <= oct_ff[N].zero ? 8'd128 : idx[31:24];
   end

   assign angle = angle_ff;

endmodule

### sv/tunnel_xor_texture_pixel.sv
// tunnel_xor_texture_pixel: top level of the tunnel pixel pipeline.
// Depends on txp_pkg, txp_div, txp_sqrt and txp_cordic.
//
//   channel   ports                              direction
//   request   start, busy, req_pix_x/y, frame    in  (busy out)
//   response  rsp_valid, rsp_pixel               out, one cycle each
//   csr       csr_we, csr_index, csr_data        in, write only
//
// One transaction enters per clock; busy is always low.
// The pipeline runs through the input stage, square stage, 32 divider stages,
// 16 square-root stages and the color/output stage. The angle path
// (the CORDIC) is delayed to line up with the depth path.
// Synchronous reset clears the valid line and the CSRs to their defaults.
// The receiver cannot stall, so the pipeline never holds.
module tunnel_xor_texture_pixel (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [8:0]                     req_pix_x,
   input  logic [7:0]                     req_pix_y,
   input  logic [7:0]                     req_frame,
   output logic                           rsp_valid,
   output logic [15:0]                    rsp_pixel,
   input  logic                           csr_we,
   input  logic [txp_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [txp_pkg::CSR_DATA_W-1:0]  csr_data
);

   // ---------------- CSRs
   logic [8:0]  center_x_ff;
   logic [7:0]  center_y_ff;
   logic [15:0] depth_scale_ff;
   logic [7:0]  rot_speed_ff;
   logic [7:0]  fly_speed_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff    <= txp_pkg::CENTER_X_RST;
         center_y_ff    <= txp_pkg::CENTER_Y_RST;
         depth_scale_ff <= txp_pkg::DEPTH_SCALE_RST;
         rot_speed_ff   <= txp_pkg::ROT_SPEED_RST;
         fly_speed_ff   <= txp_pkg::FLY_SPEED_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            txp_pkg::CSR_CENTER_X:    center_x_ff    <= csr_data[8:0];
            txp_pkg::CSR_CENTER_Y:    center_y_ff    <= csr_data[7:0];
            txp_pkg::CSR_DEPTH_SCALE: depth_scale_ff <= csr_data;
            txp_pkg::CSR_ROT_SPEED:   rot_speed_ff   <= csr_data[7:0];
            txp_pkg::CSR_FLY_SPEED:   fly_speed_ff   <= csr_data[7:0];
            default: ;   // unmapped index: dropped
         endcase
      end
   end

   assign busy = 1'b0;

   // ---------------- stage A: offsets from centre, frame offsets
   logic                                 a_valid_ff;
   logic signed [txp_pkg::DX_W-1:0]      a_dx_ff;
   logic signed [txp_pkg::DY_W-1:0]      a_dy_ff;
   txp_pkg::side_type                    a_side_ff;

   logic signed [txp_pkg::DX_W-1:0] dx_in;
   logic signed [txp_pkg::DY_W-1:0] dy_in;
   logic [15:0]                     rot_prod;
   logic [15:0]                     fly_prod;
   txp_pkg::side_type               side_in;

   always_comb begin
      dx_in    = $signed({1'b0, req_pix_x}) - $signed({1'b0, center_x_ff});
      dy_in    = $signed({1'b0, req_pix_y}) - $signed({1'b0, center_y_ff});
      rot_prod = req_frame * rot_speed_ff;
      fly_prod = req_frame * fly_speed_ff;
      side_in.zero    = (dx_in == '0) && (dy_in == '0);
      side_in.frame   = req_frame;
      side_in.rot_ofs = rot_prod[7:0];
      side_in.fly_ofs = fly_prod[7:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      a_dx_ff   <= dx_in;
      a_dy_ff   <= dy_in;
      a_side_ff <= side_in;
   end

   // ---------------- stage B: squared radius and squared scale
   logic [txp_pkg::R2_W-1:0] r2_ff;
   logic [txp_pkg::D2_W-1:0] d2_ff;
   logic [2*txp_pkg::DX_W-1:0] sq_x;
   logic [2*txp_pkg::DY_W-1:0] sq_y;
   logic [2*txp_pkg::DX_W-1:0] r2_sum;

   // operands sign-extended to the product width before squaring
   always_comb begin
      sq_x   = $unsigned((2*txp_pkg::DX_W)'(a_dx_ff) * (2*txp_pkg::DX_W)'(a_dx_ff));
      sq_y   = $unsigned((2*txp_pkg::DY_W)'(a_dy_ff) * (2*txp_pkg::DY_W)'(a_dy_ff));
      r2_sum = sq_x + {{(2*txp_pkg::DX_W-2*txp_pkg::DY_W){1'b0}}, sq_y};
   end

   always_ff @(posedge clock) begin
      r2_ff <= r2_sum[txp_pkg::R2_W-1:0];
      d2_ff <= depth_scale_ff * depth_scale_ff;
   end

   // ---------------- depth: divide, then square root
   logic [txp_pkg::D2_W-1:0]        quo;
   logic [txp_pkg::SQRT_STAGES-1:0] root;

   txp_div u_div (
      .clock (clock),
      .num   (d2_ff),
      .den   (r2_ff),
      .quo   (quo)
   );

   txp_sqrt u_sqrt (
      .clock (clock),
      .rad   (quo),
      .root  (root)
   );

   // ---------------- angle, delayed to match depth
   logic [7:0] angle;
   logic [7:0] angle_ff [txp_pkg::ANGLE_DELAY];

   txp_cordic u_cordic (
      .clock (clock),
      .dx    (a_dx_ff),
      .dy    (a_dy_ff),
      .angle (angle)
   );

   always_ff @(posedge clock) begin
      angle_ff[0] <= angle;
      for (int k = 1; k < txp_pkg::ANGLE_DELAY; k++) begin
         angle_ff[k] <= angle_ff[k-1];
      end
   end

   // ---------------- side data and valid line
   txp_pkg::side_type             side_ff [txp_pkg::SIDE_DELAY];
   logic [txp_pkg::SIDE_DELAY-1:0] valid_ff;

   always_ff @(posedge clock) begin
      side_ff[0] <= a_side_ff;
      for (int k = 1; k < txp_pkg::SIDE_DELAY; k++) begin
         side_ff[k] <= side_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[txp_pkg::SIDE_DELAY-2:0], a_valid_ff};
      end
   end

   // ---------------- texture, color and output register
   txp_pkg::side_type s_last;
   logic [7:0] depth;
   logic [7:0] tex_u;
   logic [7:0] tex_v;
   logic [7:0] tex_val;
   logic [7:0] col_r;
   logic [7:0] col_g;
   logic [7:0] col_b;
   logic [15:0] pixel_in;
   logic [15:0] rsp_pixel_ff;
   logic        rsp_valid_ff;

   always_comb begin
      s_last   = side_ff[txp_pkg::SIDE_DELAY-1];
      depth    = s_last.zero ? 8'd0 : root[7:0];
      tex_u    = angle_ff[txp_pkg::ANGLE_DELAY-1] + s_last.rot_ofs;
      tex_v    = depth + s_last.fly_ofs;
      tex_val  = tex_u ^ tex_v;
      col_r    = tex_val + s_last.frame;
      col_g    = tex_val + tex_u;
      col_b    = tex_val + tex_v;
      pixel_in = {col_r[7:3], col_g[7:2], col_b[7:3]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= valid_ff[txp_pkg::SIDE_DELAY-1];
      end
   end

   always_ff @(posedge clock) begin
      rsp_pixel_ff <= pixel_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_pixel = rsp_pixel_ff;

endmodule

### tb/tb_top.sv
// tb_top: self-checking bench for the tunnel XOR texture pixel pipeline.
// Depends on txp_pkg and the tunnel_xor_texture_pixel RTL.
// A shadow model predicts each pixel; a scoreboard compares in order.
module tb_top;

   // register indexes past the end of the list: writes must be ignored
   localparam logic [txp_pkg::CSR_INDEX_W-1:0] CSR_SPARE_LO = 3'd5;
   localparam logic [txp_pkg::CSR_INDEX_W-1:0] CSR_SPARE_HI = 3'd7;
   localparam int PIPE_LATENCY = 51;
   localparam int DRAIN_WAIT   = PIPE_LATENCY + 10;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int RANDOM_ITEMS = 1790;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [8:0] req_pix_x = '0;
   logic [7:0] req_pix_y = '0;
   logic [7:0] req_frame = '0;
   logic rsp_valid;
   logic [15:0] rsp_pixel;
   logic csr_we = 1'b0;
   logic [txp_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [txp_pkg::CSR_DATA_W-1:0] csr_data = '0;

   tunnel_xor_texture_pixel uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_pix_x(req_pix_x), .req_pix_y(req_pix_y), .req_frame(req_frame),
      .rsp_valid(rsp_valid), .rsp_pixel(rsp_pixel),
      .csr_we(csr_we), .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // shadow copy of the CSRs, tracked from the write port
   logic [8:0]  sh_center_x;
   logic [7:0]  sh_center_y;
   logic [15:0] sh_depth_scale;
   logic [7:0]  sh_rot_speed;
   logic [7:0]  sh_fly_speed;

   logic [15:0] pixel_queue[$];   // expected pixels, oldest first
   int mismatches = 0;
   int cycles = 0;
   int burst_left = 0;

   // ---------------------------------------------------------------
   // predictor
   // ---------------------------------------------------------------
   function automatic logic [31:0] int_sqrt(logic [31:0] n);
      logic [31:0] res;
      logic [31:0] bitv;
      res = '0;
      bitv = 32'h4000_0000;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n = n - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   // binary angle of (a, b), 0 <= b <= a, a > 0; exact on octant edges
   function automatic logic [31:0] octant_turn(longint a, longint b);
      longint x, y, xs, ys;
      logic [31:0] z;
      z = '0;
      if (b == 0) return 32'h0;
      if (b == a) return 32'h2000_0000;
      x = a <<< 32;
      y = b <<< 32;
      for (int i = 0; i < txp_pkg::CORDIC_STEPS; i++) begin
         xs = x >>> i;   // arithmetic shift is a floor shift
         ys = y >>> i;
         if (y >= 0) begin
            x = x + ys;
            y = y - xs;
            z = z + txp_pkg::ATAN_TAB[i];
         end else begin
            x = x - ys;
            y = y + xs;
            z = z - txp_pkg::ATAN_TAB[i];
         end
      end
      return z;
   endfunction

   function automatic logic [7:0] angle_code(int dx, int dy);
      longint ax, ay;
      logic [31:0] t, b;
      ax = (dx < 0) ? -dx : dx;
      ay = (dy < 0) ? -dy : dy;
      if (ax == 0 && ay == 0) return 8'd128;   // centre pixel
      if (ay <= ax) t = octant_turn(ax, ay);
      else t = 32'h4000_0000 - octant_turn(ay, ax);
      if (dx >= 0 && dy >= 0) b = t;
      else if (dx < 0 && dy >= 0) b = 32'h8000_0000 - t;
      else if (dx < 0) b = 32'h8000_0000 + t;
      else b = 32'h0 - t;
      b = b + 32'h8000_0000;
      return b[31:24];
   endfunction

   function automatic logic [7:0] depth_code(int dx, int dy);
      logic [31:0] r2, d2, q;
      r2 = dx * dx + dy * dy;
      d2 = 32'(sh_depth_scale) * 32'(sh_depth_scale);
      if (r2 == 0) return 8'd0;
      q = int_sqrt(d2 / r2);
      return q[7:0];
   endfunction

   function automatic logic [15:0] tunnel_pixel(logic [8:0] px, logic [7:0] py,
                                                logic [7:0] fr);
      int dx, dy;
      logic [7:0] u, v, val, r, g, b;
      dx = int'(px) - int'(sh_center_x);
      dy = int'(py) - int'(sh_center_y);
      u = angle_code(dx, dy) + fr * sh_rot_speed;
      v = depth_code(dx, dy) + fr * sh_fly_speed;
      val = u ^ v;
      r = val + fr;
      g = val + u;
      b = val + v;
      return {r[7:3], g[7:2], b[7:3]};
   endfunction

   // ---------------------------------------------------------------
   // monitor: tracks CSR writes, predicts accepted transactions,
   // and checks every response strobe against the oldest prediction
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      logic [15:0] want;
      cycles <= cycles + 1;
      if (reset) begin
         sh_center_x    <= txp_pkg::CENTER_X_RST;
         sh_center_y    <= txp_pkg::CENTER_Y_RST;
         sh_depth_scale <= txp_pkg::DEPTH_SCALE_RST;
         sh_rot_speed   <= txp_pkg::ROT_SPEED_RST;
         sh_fly_speed   <= txp_pkg::FLY_SPEED_RST;
      end else begin
         if (csr_we) begin
            case (csr_index)
               txp_pkg::CSR_CENTER_X:    sh_center_x    <= csr_data[8:0];
               txp_pkg::CSR_CENTER_Y:    sh_center_y    <= csr_data[7:0];
               txp_pkg::CSR_DEPTH_SCALE: sh_depth_scale <= csr_data;
               txp_pkg::CSR_ROT_SPEED:   sh_rot_speed   <= csr_data[7:0];
               txp_pkg::CSR_FLY_SPEED:   sh_fly_speed   <= csr_data[7:0];
               default: ;
            endcase
         end
         if (start && !busy)
            pixel_queue.push_back(tunnel_pixel(req_pix_x, req_pix_y, req_frame));
         if (rsp_valid) begin
            if (pixel_queue.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("ERROR: unexpected pixel %h at cycle %0d", rsp_pixel, cycles);
            end else begin
               want = pixel_queue.pop_front();
               if (rsp_pixel !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("ERROR: pixel expected %h got %h at cycle %0d",
                              want, rsp_pixel, cycles);
               end
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (cycles > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // drivers (all called at a falling edge, return at a falling edge)
   // ---------------------------------------------------------------
   // one transaction; start stays high inside a burst, drops for a gap
   task automatic send_pixel(logic [8:0] px, logic [7:0] py, logic [7:0] fr);
      int gap;
      start = 1'b1;
      req_pix_x = px;
      req_pix_y = py;
      req_frame = fr;
      forever begin
         @(posedge clock);
         if (!busy) break;
      end
      @(negedge clock);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         start = 1'b0;
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         repeat (gap) @(negedge clock);
         // long bursts give stretches with no idling at all
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(0, 8);
      end
   endtask

   // wait for the pipeline to empty before touching the CSRs
   task automatic drain_pipe();
      start = 1'b0;
      while (pixel_queue.size() != 0) @(negedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);
   endtask

   task automatic write_csr(logic [txp_pkg::CSR_INDEX_W-1:0] idx,
                            logic [txp_pkg::CSR_DATA_W-1:0] val);
      csr_we = 1'b1;
      csr_index = idx;
      csr_data = val;
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic set_tunnel(logic [8:0] cx, logic [7:0] cy, logic [15:0] ds,
                             logic [7:0] rs, logic [7:0] fs);
      logic [15:0] junk;
      drain_pipe();
      // upper data bits beyond each register's width must be dropped
      junk = 16'($urandom);
      write_csr(txp_pkg::CSR_CENTER_X,    {junk[15:9], cx});
      write_csr(txp_pkg::CSR_CENTER_Y,    {junk[15:8], cy});
      write_csr(txp_pkg::CSR_DEPTH_SCALE, ds);
      write_csr(txp_pkg::CSR_ROT_SPEED,   {junk[7:0], rs});
      write_csr(txp_pkg::CSR_FLY_SPEED,   {junk[7:0], fs});
   endtask

   function automatic logic [8:0] rand_x();
      return ($urandom_range(0, 7) == 0) ? 9'($urandom) : 9'($urandom_range(0, 319));
   endfunction

   function automatic logic [7:0] rand_y();
      return ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 239));
   endfunction

   // ---------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------
   // reset defaults; centre pixel, axis and diagonal directions, extremes
   task automatic test_directed();
      send_pixel(9'd160, 8'd120, 8'd0);     // centre pixel
      send_pixel(9'd160, 8'd120, 8'd255);
      send_pixel(9'd100, 8'd120, 8'd3);     // direction pi
      send_pixel(9'd200, 8'd120, 8'd3);     // direction 0
      send_pixel(9'd160, 8'd0,   8'd7);     // straight up
      send_pixel(9'd160, 8'd239, 8'd7);     // straight down
      send_pixel(9'd170, 8'd130, 8'd1);     // diagonals
      send_pixel(9'd150, 8'd130, 8'd1);
      send_pixel(9'd150, 8'd110, 8'd1);
      send_pixel(9'd170, 8'd110, 8'd1);
      send_pixel(9'd161, 8'd120, 8'd9);     // nearest neighbours
      send_pixel(9'd160, 8'd121, 8'd9);
      send_pixel(9'd0,   8'd0,   8'd0);     // field extremes
      send_pixel(9'd511, 8'd255, 8'd255);
      send_pixel(9'd319, 8'd239, 8'd128);
      send_pixel(9'd0,   8'd255, 8'd85);
      send_pixel(9'd511, 8'd0,   8'd170);
   endtask

   // CSR extremes, including a zero depth scale and a centre off the image
   task automatic test_csr_extremes();
      set_tunnel(9'd0, 8'd0, 16'hFFFF, 8'd255, 8'd255);
      write_csr(CSR_SPARE_LO, 16'h0000);   // unused indexes are ignored
      write_csr(CSR_SPARE_HI, 16'hFFFF);
      repeat (30) send_pixel(9'($urandom), 8'($urandom), 8'($urandom));
      set_tunnel(9'd511, 8'd255, 16'd0, 8'd0, 8'd0);
      repeat (30) send_pixel(9'($urandom), 8'($urandom), 8'($urandom));
      set_tunnel(9'd319, 8'd239, 16'd1, 8'd1, 8'd128);
      send_pixel(9'd319, 8'd239, 8'd5);
      send_pixel(9'd0, 8'd239, 8'd5);
      repeat (30) send_pixel(rand_x(), rand_y(), 8'($urandom));
   endtask

   // random pixels over a series of random tunnel settings
   task automatic test_random();
      int chunk;
      for (int n = 0; n < RANDOM_ITEMS; n += chunk) begin
         chunk = $urandom_range(150, 400);
         if (chunk > RANDOM_ITEMS - n) chunk = RANDOM_ITEMS - n;
         set_tunnel(($urandom_range(0, 3) == 0) ? 9'($urandom) : 9'($urandom_range(0, 319)),
                    ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 239)),
                    16'($urandom), 8'($urandom), 8'($urandom));
         repeat (chunk) begin
            // some pixels near the centre, where depth is large and angles coarse
            if ($urandom_range(0, 9) == 0)
               send_pixel(9'(sh_center_x + 9'($urandom_range(0, 6)) - 9'd3),
                          8'(sh_center_y + 8'($urandom_range(0, 6)) - 8'd3),
                          8'($urandom));
            else
               send_pixel(rand_x(), rand_y(), 8'($urandom));
         end
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_csr_extremes();
      test_random();
      drain_pipe();
      if (mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

### tunnel_xor_texture_pixel.f
sv/txp_pkg.sv
sv/txp_div.sv
sv/txp_sqrt.sv
sv/txp_cordic.sv
sv/tunnel_xor_texture_pixel.sv
tb/tb_top.sv
